// ===== design/zone_bounce_chaser_trail_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the zone bounce chaser trail block
// Each macro expands to a clocked concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ZONE_BOUNCE_CHASER_TRAIL_MACROS_SVH
`define ZONE_BOUNCE_CHASER_TRAIL_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ZBCT_ASSERT_IMPLY(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("zbct: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZBCT_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("zbct: next-cycle check failed");

`else

`define ZBCT_ASSERT_IMPLY(label, ck, rs, ante, cons)
`define ZBCT_ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

// ===== design/zbct_pkg.sv =====
// ---------------------------------------------------------------------------
// Zone bounce chaser trail package
// Strip geometry, register indexes, arithmetic constants, sequencer states
// and zone bound functions.
// ---------------------------------------------------------------------------
package zbct_pkg;

  localparam int PIXEL_COUNT = 512;
  localparam int ADDR_W      = $clog2(PIXEL_COUNT);
  localparam int QUARTER     = PIXEL_COUNT / 4;
  localparam int IDX_W       = 9;
  localparam int SPEED_W     = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  typedef logic [23:0]       rgb_t;
  typedef logic [ADDR_W-1:0] pix_addr_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ONE_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_TWO_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_THREE_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_FOUR_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SETTING    = 3'd4;

  localparam rgb_t                ZONE_ONE_RESET   = 24'hFF0000;
  localparam rgb_t                ZONE_TWO_RESET   = 24'h00FF00;
  localparam rgb_t                ZONE_THREE_RESET = 24'h0000FF;
  localparam rgb_t                ZONE_FOUR_RESET  = 24'hFFFFFF;
  localparam logic [SPEED_W-1:0]  SPEED_RESET      = 7'd60;

  // Increment map: q + trunc((s-1)*(5-q)/119), the division done as a
  // multiplication by ceil(2^20/119), exact for magnitudes below 2^13.
  localparam int PROD_W     = 15;
  localparam int MAG_W      = 14;
  localparam int RECIP_W    = 28;
  localparam int DIV_SHIFT  = 20;
  localparam int DIV_RECIP  = 8812;
  localparam int INC_BASE   = 5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MAX,
    ST_MUL,
    ST_DIV,
    ST_INC,
    ST_SWEEP,
    ST_DRAIN,
    ST_PUT
  } state_t;

  function automatic pix_addr_t zone_start(input logic [1:0] z);
    case (z)
      2'd0:    return '0;
      2'd1:    return ADDR_W'(QUARTER);
      2'd2:    return ADDR_W'(PIXEL_COUNT / 2);
      default: return ADDR_W'(PIXEL_COUNT / 2 + QUARTER);
    endcase
  endfunction

  // Zone four turns one pixel before the end of the strip.
  function automatic pix_addr_t zone_end(input logic [1:0] z);
    case (z)
      2'd0:    return ADDR_W'(QUARTER - 1);
      2'd1:    return ADDR_W'(2 * QUARTER - 1);
      2'd2:    return ADDR_W'(PIXEL_COUNT / 2 + QUARTER - 1);
      default: return ADDR_W'(PIXEL_COUNT - 2);
    endcase
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] decay8(input logic [7:0] x);
    logic [10:0] prod;
    prod = {3'b000, x} * 11'd7;
    return prod[10:3];
  endfunction

endpackage

// ===== design/zone_bounce_chaser_trail.sv =====
// ---------------------------------------------------------------------------
// Zone bounce chaser trail
// Four-zone bouncing chaser scanner with a fading trail. The strip lives in
// a pixel memory that a frame step sweeps with read, decay and write back.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_ready   | kind, pixel_index
//   out     | output    | out_valid / out_ready | red/green/blue_level,
//           |           |                       | sweep_done, frame_level
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A frame step runs from acceptance through the increment arithmetic in the
// max, multiply, divide and increment states, then one pixel per cycle through
// the single write port of the pixel memory, then drain and output.
// A read item reads the memory as it is accepted; the registered read data
// goes into the result in ST_READ. After reset a clearing pass writes every
// pixel black; no item is accepted meanwhile, configuration writes are.
// One item is in work at a time; a result held by out_ready stalls only the
// next item's completion, not its acceptance.
// ---------------------------------------------------------------------------
`include "zone_bounce_chaser_trail_macros.svh"

module zone_bounce_chaser_trail (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [zbct_pkg::IDX_W-1:0]      pixel_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      red_level,
  output logic [7:0]                      green_level,
  output logic [7:0]                      blue_level,
  output logic                            sweep_done,
  output logic [7:0]                      frame_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [zbct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zbct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zbct_pkg::*;

  localparam pix_addr_t LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

  state_t state, state_next;

  // Configuration registers.
  rgb_t               zone_color [4];
  logic [SPEED_W-1:0] speed_setting;

  // Animation state.
  logic [8:0] sweep_level;
  pix_addr_t  chaser_position [4];
  logic       chaser_reverse [4];
  rgb_t       chaser_fade_color [4];
  pix_addr_t  chaser_position_next [4];
  logic       chaser_reverse_next [4];
  rgb_t       chaser_fade_color_next [4];

  // Pixel memory.
  rgb_t      pixel_store [PIXEL_COUNT];
  logic      mem_we, mem_re;
  pix_addr_t mem_waddr, mem_raddr;
  rgb_t      mem_wdata, mem_rdata;

  // Sequencer and arithmetic registers.
  pix_addr_t          cnt;
  logic               wb_valid;
  pix_addr_t          wb_addr;
  logic               rd_in_range;
  logic [7:0]         maxc;
  logic signed [PROD_W-1:0] prod;
  logic [6:0]         quot;
  logic               quot_neg;
  logic               frame_end;

  // Result held until the output register is free.
  rgb_t       res_rgb;
  logic       res_done;
  logic [7:0] res_level;

  // Combinational helpers.
  logic [7:0]              maxc_c;
  logic signed [8:0]       speed_m1;
  logic signed [7:0]       q_span;
  logic [MAG_W-1:0]        mag_c;
  logic [RECIP_W-1:0]      recip_c;
  logic signed [8:0]       inc_s;
  logic [8:0]              inc_u;
  logic [9:0]              level_sum;
  logic                    done_c;
  logic                    hit_c;
  rgb_t                    hit_color_c;
  rgb_t                    decay_c;
  logic                    load_out;

  assign cfg_ready = 1'b1;

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cnt == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_next = kind ? ST_READ : ST_MAX;
      end
      ST_READ:  state_next = ST_PUT;
      ST_MAX:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_INC;
      ST_INC:   state_next = ST_SWEEP;
      ST_SWEEP: if (cnt == LAST_ADDR) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_PUT;
      ST_PUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer outputs: handshake and memory ports
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wb_addr;
    mem_wdata = hit_c ? hit_color_c : decay_c;
    mem_re    = 1'b0;
    mem_raddr = cnt;
    load_out  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_re    = in_valid && kind;
        mem_raddr = ADDR_W'(pixel_index);
      end
      ST_SWEEP: begin
        mem_re = 1'b1;
        mem_we = wb_valid;
      end
      ST_DRAIN: mem_we = wb_valid;
      ST_PUT:   load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Increment arithmetic and chaser colours
  // -------------------------------------------------------------------------
  always_comb begin
    logic [7:0] zmax [4];
    for (int z = 0; z < 4; z++) begin
      zmax[z] = max8(max8(zone_color[z][23:16], zone_color[z][15:8]), zone_color[z][7:0]);
    end
    maxc_c = max8(max8(zmax[0], zmax[1]), max8(zmax[2], zmax[3]));

    speed_m1 = $signed({2'b00, speed_setting}) - 9'sd1;
    q_span   = 8'(INC_BASE) - $signed({2'b00, maxc[7:2]});

    mag_c   = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
    recip_c = RECIP_W'(mag_c) * RECIP_W'(DIV_RECIP);

    inc_s = $signed({3'b000, maxc[7:2]})
          + (quot_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot}));
    inc_u = (inc_s < 9'sd1) ? 9'd1 : unsigned'(inc_s);

    level_sum = {1'b0, sweep_level} + {1'b0, inc_u};
    done_c    = level_sum > {2'b00, maxc};

    // A chaser channel follows the level while the level is within its
    // zone colour channel.
    for (int z = 0; z < 4; z++) begin
      chaser_fade_color_next[z] = chaser_fade_color[z];
      for (int k = 0; k < 3; k++) begin
        if (sweep_level <= {1'b0, zone_color[z][8*k +: 8]}) begin
          chaser_fade_color_next[z][8*k +: 8] = sweep_level[7:0];
        end
      end
    end
  end

  // Write-back data: a chaser pixel takes its colour, every other one decays.
  always_comb begin
    hit_c       = 1'b0;
    hit_color_c = '0;
    for (int z = 0; z < 4; z++) begin
      if (wb_addr == chaser_position[z]) begin
        hit_c       = 1'b1;
        hit_color_c = chaser_fade_color[z];
      end
    end
    decay_c = {decay8(mem_rdata[23:16]), decay8(mem_rdata[15:8]), decay8(mem_rdata[7:0])};
  end

  // Chaser step and bounce, taken in the drain of a frame step that ends the level ramp.
  always_comb begin
    pix_addr_t p;
    logic      r;
    for (int z = 0; z < 4; z++) begin
      p = chaser_position[z];
      r = chaser_reverse[z];
      if (r) begin
        p = (p != '0) ? p - 1'b1 : '0;
      end else begin
        p = p + 1'b1;
      end
      if (p <= zone_start(2'(z))) begin
        p = zone_start(2'(z));
        r = 1'b0;
      end
      if (p >= zone_end(2'(z))) begin
        p = zone_end(2'(z));
        r = 1'b1;
      end
      chaser_position_next[z] = p;
      chaser_reverse_next[z]  = r;
    end
  end

  // -------------------------------------------------------------------------
  // Pixel memory
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) pixel_store[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= pixel_store[mem_raddr];
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      cnt           <= '0;
      wb_valid      <= 1'b0;
      out_valid     <= 1'b0;
      sweep_level   <= '0;
      speed_setting <= SPEED_RESET;
      zone_color[0] <= ZONE_ONE_RESET;
      zone_color[1] <= ZONE_TWO_RESET;
      zone_color[2] <= ZONE_THREE_RESET;
      zone_color[3] <= ZONE_FOUR_RESET;
      for (int z = 0; z < 4; z++) begin
        chaser_position[z]   <= zone_start(2'(z));
        chaser_reverse[z]    <= 1'b0;
        chaser_fade_color[z] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZONE_ONE_COLOR:   zone_color[0] <= cfg_data[23:0];
          REG_ZONE_TWO_COLOR:   zone_color[1] <= cfg_data[23:0];
          REG_ZONE_THREE_COLOR: zone_color[2] <= cfg_data[23:0];
          REG_ZONE_FOUR_COLOR:  zone_color[3] <= cfg_data[23:0];
          REG_SPEED_SETTING:    speed_setting <= cfg_data[SPEED_W-1:0];
          default: begin
          end
        endcase
      end

      wb_valid <= (state == ST_SWEEP);
      wb_addr  <= cnt;

      case (state)
        ST_CLEAR, ST_SWEEP: cnt <= (cnt == LAST_ADDR) ? '0 : cnt + 1'b1;
        ST_IDLE: rd_in_range <= 32'(pixel_index) < 32'(PIXEL_COUNT);
        ST_READ: begin
          res_rgb   <= rd_in_range ? mem_rdata : '0;
          res_done  <= 1'b0;
          res_level <= '0;
        end
        ST_MAX: maxc <= maxc_c;
        ST_MUL: prod <= PROD_W'(speed_m1) * PROD_W'(q_span);
        ST_DIV: begin
          quot     <= recip_c[DIV_SHIFT +: 7];
          quot_neg <= prod[PROD_W-1];
        end
        ST_INC: begin
          cnt         <= '0;
          res_rgb     <= '0;
          res_done    <= done_c;
          res_level   <= sweep_level[7:0];
          frame_end   <= done_c;
          sweep_level <= done_c ? 9'd0 : level_sum[8:0];
          for (int z = 0; z < 4; z++) begin
            chaser_fade_color[z] <= chaser_fade_color_next[z];
          end
        end
        ST_DRAIN: begin
          if (frame_end) begin
            for (int z = 0; z < 4; z++) begin
              chaser_position[z] <= chaser_position_next[z];
              chaser_reverse[z]  <= chaser_reverse_next[z];
            end
          end
        end
        default: begin
        end
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_level   <= res_rgb[23:16];
      green_level <= res_rgb[15:8];
      blue_level  <= res_rgb[7:0];
      sweep_done  <= res_done;
      frame_level <= res_level;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ZBCT_ASSERT_IMPLY(a_no_same_entry, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr)
  `ZBCT_ASSERT_IMPLY(a_level_in_byte, clk, rst, 1'b1, !sweep_level[8])
  `ZBCT_ASSERT_IMPLY(a_zone_four_bounds, clk, rst, 1'b1, (chaser_position[3] >= zone_start(2'd3)) && (chaser_position[3] <= zone_end(2'd3)))
  `ZBCT_ASSERT_IMPLY(a_wb_in_sweep, clk, rst, wb_valid, (state == ST_SWEEP) || (state == ST_DRAIN))
  `ZBCT_ASSERT_NEXT(a_drain_to_put, clk, rst, state == ST_DRAIN, state == ST_PUT)

endmodule
